>>> sv/hrrn_scheduler_defines.svh
// Assertion macros for the scheduler RTL.
`ifndef HRRN_SCHEDULER_DEFINES_SVH
`define HRRN_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF

`define HRRN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HRRN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define HRRN_ASSERT(label, prop, msg)

`define HRRN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> sv/hrrn_pkg.sv
package hrrn_pkg;

    localparam int MAX_PROCS = 64;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int ID_W      = 16;
    localparam int TICK_W    = 16;
    localparam int TIME_W    = 23;
    localparam int NUM_W     = TIME_W + 1;
    localparam int PROD_W    = NUM_W + TICK_W;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]   proc_id;
        logic [TICK_W-1:0] arrive_at;
        logic [TICK_W-1:0] run_len;
        logic              last_in;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] finish_at;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              last_out;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] arr;
        logic [TICK_W-1:0] bur;
    } entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_MUL,
        ST_CMP,
        ST_DECIDE,
        ST_ADVANCE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic mul;
        logic cmp;
        logic jump;
        logic dispatch;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_in;
        logic scan_last;
        logic found;
        logic out_free;
        logic final_done;
    } status_t;

endpackage

>>> sv/hrrn_scheduler.sv
// Highest-response-ratio-next scheduler.
// Request channel (req_valid, req_stall, req): one process per request with
// id, arrival and burst; a burst of zero counts as one. Up to MAX_PROCS
// requests fill the table, further ones are dropped; last_in ends the set.
// req_stall stays low only while loading, so the set is taken at one
// request per cycle and then held off until the final result of the set
// has been placed in the output register.
// Result channel (rsp_valid, rsp_stall, rsp): one result per dispatch in
// dispatch order, with completion, turnaround and waiting time; last_out
// marks the final one. A stalled result holds in the output register and
// the scan for the next dispatch waits for it to leave.
// Each dispatch scans all n loaded entries through one shared multiply and
// compare unit, one entry after the other; when no open entry has arrived
// yet, the clock jumps over the idle gap to the earliest open arrival and
// the scan repeats.
// Reset empties the table, clears the completion marks and the clock, and
// drops any result held in the output register.
module hrrn_scheduler (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  hrrn_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hrrn_pkg::rsp_t rsp
);

    hrrn_pkg::cmd_t    cmd;
    hrrn_pkg::status_t status;

    hrrn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hrrn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> sv/hrrn_ctrl.sv
module hrrn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  hrrn_pkg::status_t status,
    output hrrn_pkg::cmd_t    cmd
);

    hrrn_pkg::state_t state_reg;
    hrrn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrrn_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hrrn_pkg::ST_LOAD:
            begin
                if (req_valid && status.last_in)
                begin
                    state_next = hrrn_pkg::ST_PREP;
                end
            end
            hrrn_pkg::ST_PREP:
            begin
                state_next = hrrn_pkg::ST_MUL;
            end
            hrrn_pkg::ST_MUL:
            begin
                state_next = hrrn_pkg::ST_CMP;
            end
            hrrn_pkg::ST_CMP:
            begin
                state_next = status.scan_last ? hrrn_pkg::ST_DECIDE : hrrn_pkg::ST_MUL;
            end
            hrrn_pkg::ST_DECIDE:
            begin
                state_next = status.found ? hrrn_pkg::ST_ADVANCE : hrrn_pkg::ST_MUL;
            end
            hrrn_pkg::ST_ADVANCE:
            begin
                state_next = hrrn_pkg::ST_EMIT;
            end
            hrrn_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_done ? hrrn_pkg::ST_LOAD : hrrn_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = hrrn_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            hrrn_pkg::ST_LOAD:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            hrrn_pkg::ST_PREP:
            begin
                cmd.scan_start = 1'b1;
            end
            hrrn_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            hrrn_pkg::ST_CMP:
            begin
                cmd.cmp = 1'b1;
            end
            hrrn_pkg::ST_DECIDE:
            begin
                cmd.jump       = !status.found;
                cmd.scan_start = !status.found;
            end
            hrrn_pkg::ST_ADVANCE:
            begin
                cmd.dispatch = 1'b1;
            end
            hrrn_pkg::ST_EMIT:
            begin
                cmd.emit       = status.out_free;
                cmd.finish     = status.out_free && status.final_done;
                cmd.scan_start = status.out_free && !status.final_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/hrrn_datapath.sv
`include "hrrn_scheduler_defines.svh"

module hrrn_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  hrrn_pkg::req_t    req,
    input  hrrn_pkg::cmd_t    cmd,
    output hrrn_pkg::status_t status,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output hrrn_pkg::rsp_t    rsp
);

    localparam int IDX_W  = hrrn_pkg::IDX_W;
    localparam int CNT_W  = hrrn_pkg::CNT_W;
    localparam int TICK_W = hrrn_pkg::TICK_W;
    localparam int TIME_W = hrrn_pkg::TIME_W;
    localparam int NUM_W  = hrrn_pkg::NUM_W;
    localparam int PROD_W = hrrn_pkg::PROD_W;
    localparam int MAXP   = hrrn_pkg::MAX_PROCS;

    hrrn_pkg::entry_t mem [MAXP];
    hrrn_pkg::entry_t rd_reg;
    hrrn_pkg::entry_t wr_entry;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]  disp_cnt_reg, disp_cnt_next;
    logic [MAXP-1:0]   done_reg, done_next;
    logic [TIME_W-1:0] time_reg, time_next;

    logic [NUM_W-1:0]  cand_na;
    logic [NUM_W-1:0]  cand_na_reg;
    logic [PROD_W-1:0] lhs_reg, rhs_reg;
    logic              elig_reg, unc_reg;

    hrrn_pkg::entry_t  best_reg;
    logic [NUM_W-1:0]  best_na_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              found_reg, found_next;
    logic [TICK_W-1:0] min_arr_reg, min_arr_next;
    logic              better;
    logic              take;

    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;
    logic [TIME_W-1:0] turn;
    logic [TIME_W-1:0] wait_len;

    logic              rsp_valid_reg, rsp_valid_next;
    hrrn_pkg::rsp_t    rsp_reg;

    assign wr_en          = cmd.load && (load_cnt_reg < CNT_W'(MAXP));
    assign wr_entry.id    = req.proc_id;
    assign wr_entry.arr   = req.arrive_at;
    assign wr_entry.bur   = (req.run_len == '0) ? TICK_W'(1) : req.run_len;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.cmp)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign rd_addr = idx_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[load_cnt_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_reg <= mem[rd_addr];
    end

    assign cand_na = {1'b0, time_reg} - NUM_W'(rd_reg.arr) + NUM_W'(rd_reg.bur);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            cand_na_reg <= cand_na;
            lhs_reg     <= PROD_W'(cand_na) * PROD_W'(best_reg.bur);
            rhs_reg     <= PROD_W'(best_na_reg) * PROD_W'(rd_reg.bur);
            elig_reg    <= !done_reg[idx_reg] && (TIME_W'(rd_reg.arr) <= time_reg);
            unc_reg     <= !done_reg[idx_reg];
        end
    end

    assign better = !found_reg || (lhs_reg > rhs_reg) ||
                    ((lhs_reg == rhs_reg) &&
                     ((rd_reg.arr < best_reg.arr) ||
                      ((rd_reg.arr == best_reg.arr) && (rd_reg.id < best_reg.id))));
    assign take   = cmd.cmp && elig_reg && better;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= rd_reg;
            best_na_reg  <= cand_na_reg;
            best_idx_reg <= idx_reg;
        end
    end

    always_comb
    begin
        found_next   = found_reg;
        min_arr_next = min_arr_reg;
        if (cmd.scan_start)
        begin
            found_next   = 1'b0;
            min_arr_next = '1;
        end
        else if (cmd.cmp)
        begin
            if (take)
            begin
                found_next = 1'b1;
            end
            if (unc_reg && (rd_reg.arr < min_arr_reg))
            begin
                min_arr_next = rd_reg.arr;
            end
        end
    end

    assign time_sum = {1'b0, time_reg} + (TIME_W + 1)'(best_reg.bur);
    assign time_sat = time_sum[TIME_W] ? hrrn_pkg::TIME_MAX : time_sum[TIME_W-1:0];

    always_comb
    begin
        time_next     = time_reg;
        load_cnt_next = load_cnt_reg;
        disp_cnt_next = disp_cnt_reg;
        done_next     = done_reg;
        if (cmd.load && req.last_in)
        begin
            time_next = '0;
        end
        if (wr_en)
        begin
            done_next[load_cnt_reg[IDX_W-1:0]] = 1'b0;
            load_cnt_next                      = load_cnt_reg + CNT_W'(1);
        end
        if (cmd.jump)
        begin
            time_next = TIME_W'(min_arr_reg);
        end
        if (cmd.dispatch)
        begin
            time_next              = time_sat;
            done_next[best_idx_reg] = 1'b1;
            disp_cnt_next          = disp_cnt_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            load_cnt_next = '0;
            disp_cnt_next = '0;
        end
    end

    assign turn     = (time_reg > TIME_W'(best_reg.arr)) ?
                      (time_reg - TIME_W'(best_reg.arr)) : '0;
    assign wait_len = (turn > TIME_W'(best_reg.bur)) ? (turn - TIME_W'(best_reg.bur)) : '0;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.done_id         <= best_reg.id;
            rsp_reg.finish_at       <= time_reg;
            rsp_reg.turnaround_time <= turn;
            rsp_reg.waiting_time    <= wait_len;
            rsp_reg.last_out        <= (disp_cnt_reg == load_cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            load_cnt_reg  <= '0;
            disp_cnt_reg  <= '0;
            done_reg      <= '0;
            time_reg      <= '0;
            found_reg     <= 1'b0;
            min_arr_reg   <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            load_cnt_reg  <= load_cnt_next;
            disp_cnt_reg  <= disp_cnt_next;
            done_reg      <= done_next;
            time_reg      <= time_next;
            found_reg     <= found_next;
            min_arr_reg   <= min_arr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign status.last_in    = req.last_in;
    assign status.scan_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == load_cnt_reg;
    assign status.found      = found_reg;
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;
    assign status.final_done = (disp_cnt_reg == load_cnt_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `HRRN_ASSERT(a_load_bound, load_cnt_reg <= CNT_W'(MAXP), "load count beyond table")
    `HRRN_ASSERT(a_disp_bound, disp_cnt_reg <= load_cnt_reg, "more dispatches than requests")
    `HRRN_ASSERT(a_pick_open, cmd.dispatch |-> found_reg && !done_reg[best_idx_reg], "bad pick")
    `HRRN_ASSERT_NEXT(a_mark_done, cmd.dispatch, done_reg[best_idx_reg], "pick not marked")
    `HRRN_ASSERT(a_emit_time, cmd.emit |-> time_reg >= TIME_W'(best_reg.arr), "early finish")

endmodule
